>>> hdl/tlfpd_pkg.sv
// ----------------------------------------------------------------------------
// tlfpd_pkg: shared types, codes and helpers
// Result record, character codes and parser progress codes for the link byte
// splitter.
// ----------------------------------------------------------------------------
package tlfpd_pkg;

    localparam int LINE_MAX_DEF = 128;
    localparam int ARM_LEN_DEF  = 16;

    // result queue between the parser and the output port
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;

    // routes
    localparam logic [1:0] ROUTE_NONE    = 2'd0;
    localparam logic [1:0] ROUTE_ROVER   = 2'd1;
    localparam logic [1:0] ROUTE_SCIENCE = 2'd2;
    localparam logic [1:0] ROUTE_ARM     = 2'd3;

    // characters
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_3      = 8'h33;
    localparam logic [7:0] CH_4      = 8'h34;
    localparam logic [7:0] CH_5      = 8'h35;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_X_LOW  = 8'h78;

    localparam logic [11:0] ID_MAX = 12'h7FF;

    // prefix check progress
    localparam logic [3:0] PROG_START   = 4'd0;
    localparam logic [3:0] PROG_ZERO    = 4'd1;
    localparam logic [3:0] PROG_X       = 4'd2;
    localparam logic [3:0] PROG_D1      = 4'd3;
    localparam logic [3:0] PROG_N_COMMA = 4'd4;  // normal mode: comma read
    localparam logic [3:0] PROG_D2      = 4'd4;  // science mode: second digit read
    localparam logic [3:0] PROG_D3      = 4'd5;
    localparam logic [3:0] PROG_S_COMMA = 4'd6;
    localparam logic [3:0] PROG_S_TAIL  = 4'd7;
    localparam logic [3:0] PROG_FAILED  = 4'd15;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [6:0] position;
        logic [1:0] route;
        logic [7:0] packet_length;
        logic       last;
    } t_result;

    // results caused by one byte, in order
    typedef struct packed {
        t_result    r0;
        t_result    r1;
        logic [1:0] num;
    } t_step;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = b - 8'h37;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = b - 8'h57;
        end
        return v[3:0];
    endfunction

    function automatic t_result make_data(input logic [7:0] b, input logic [6:0] pos,
                                          input logic [1:0] route);
        t_result r;
        r.kind          = KIND_DATA;
        r.data_byte     = b;
        r.position      = pos;
        r.route         = route;
        r.packet_length = 8'd0;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic t_result make_marker(input logic [1:0] kind, input logic [1:0] route,
                                            input logic [7:0] len);
        t_result r;
        r.kind          = kind;
        r.data_byte     = 8'd0;
        r.position      = 7'd0;
        r.route         = route;
        r.packet_length = len;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

>>> hdl/text_line_and_fixed_packet_demux.sv
// ----------------------------------------------------------------------------
// text_line_and_fixed_packet_demux: link byte packet splitter
// A result is written into the result queue when its byte is taken; the master side reads the queue head.
// Throughput: one byte per cycle while each byte gives at most one result and
//   the master side takes every result; a byte that gives two results needs two
//   transfers on the single output port, and a 4-entry result queue takes up the difference.
// Reset: synchronous, active low; clears the mode to normal, the parser state
//   and the result queue.
// ----------------------------------------------------------------------------
module text_line_and_fixed_packet_demux #(
    parameter int LINE_MAX = tlfpd_pkg::LINE_MAX_DEF,
    parameter int ARM_LEN  = tlfpd_pkg::ARM_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // science_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // data_byte[7:0], position[14:8], route[16:15],
                                         // packet_length[24:17], zeros above
    output logic [1:0]  m_axis_tuser,    // kind
    output logic        m_axis_tlast     // last_of_step
);
    import tlfpd_pkg::*;

    t_result          r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             in_accept, out_accept;
    t_step            step;
    t_result          head;
    logic [1:0]       push;

    tlfpd_parser #(
        .LINE_MAX (LINE_MAX),
        .ARM_LEN  (ARM_LEN)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (in_accept),
        .i_byte      (s_axis_tdata),
        .o_step      (step)
    );

    // room for two results keeps input and output decoupled
    assign s_axis_tready = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign out_accept    = m_axis_tvalid && m_axis_tready;
    assign push          = in_accept ? step.num : 2'd0;

    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tdata  = {7'd0, head.packet_length, head.route, head.position,
                            head.data_byte};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_fifo[r_wr_ptr] <= step.r0;
        end
        if (push == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= step.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push);
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push) - CNT_W'(out_accept);
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < CNT_W'(FIFO_DEPTH)) |-> (PTR_W'(r_wr_ptr - r_rd_ptr) == PTR_W'(r_count)))
        else $error("queue pointers disagree with fill count");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push == 2'd2) |=> (r_count >= CNT_W'(1)))
        else $error("two-result push lost");

endmodule

>>> hdl/tlfpd_parser.sv
// ----------------------------------------------------------------------------
// tlfpd_parser: per-byte line and arm packet parser
// Holds the mode register and the running parse state; works out the zero, one or
// two results of each accepted byte combinationally.
// ----------------------------------------------------------------------------
module tlfpd_parser #(
    parameter int LINE_MAX = tlfpd_pkg::LINE_MAX_DEF,
    parameter int ARM_LEN  = tlfpd_pkg::ARM_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    output tlfpd_pkg::t_step o_step
);
    import tlfpd_pkg::*;

    localparam int LC_W = $clog2(LINE_MAX + 1);
    localparam int AC_W = $clog2(ARM_LEN + 1);

    logic            r_science;
    logic            r_in_arm,  n_in_arm;
    logic            r_held_j,  n_held_j;
    logic [LC_W-1:0] r_count,   n_count;
    logic            r_ovf,     n_ovf;
    logic [AC_W-1:0] r_arm,     n_arm;
    logic [3:0]      r_prog,    n_prog;
    logic [11:0]     r_id,      n_id;
    logic            r_comma,   n_comma;
    logic            r_tail,    n_tail;
    logic [1:0]      r_class,   n_class;

    logic [LC_W-1:0] eff_count;
    logic [3:0]      eff_prog;
    logic            ok;
    logic            go;
    logic [15:0]     id_next;
    logic [AC_W-1:0] arm_inc;
    logic            have_pre, have_m0, have_m1;
    t_result         pre, m0, m1;
    t_step           step;

    always_comb begin
        n_in_arm = r_in_arm;
        n_held_j = r_held_j;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_arm    = r_arm;
        n_prog   = r_prog;
        n_id     = r_id;
        n_comma  = r_comma;
        n_tail   = r_tail;
        n_class  = r_class;
        eff_count = r_count;
        eff_prog  = r_prog;
        ok       = 1'b0;
        go       = 1'b1;
        id_next  = {r_id, hex_val(i_byte)};
        arm_inc  = r_arm + AC_W'(1);
        have_pre = 1'b0;
        have_m0  = 1'b0;
        have_m1  = 1'b0;
        pre      = '0;
        m0       = '0;
        m1       = '0;

        if (!r_science) begin
            if (r_in_arm) begin
                have_m0 = 1'b1;
                m0      = make_data(i_byte, 7'(r_arm), ROUTE_ARM);
                n_arm   = arm_inc;
                if (arm_inc == AC_W'(ARM_LEN)) begin
                    have_m1  = 1'b1;
                    m1       = make_marker(KIND_ACCEPT, ROUTE_ARM, 8'(ARM_LEN));
                    n_in_arm = 1'b0;
                    n_arm    = '0;
                end
            end else begin
                if (r_held_j) begin
                    n_held_j = 1'b0;
                    if (i_byte == CH_F) begin
                        have_m0  = 1'b1;
                        have_m1  = 1'b1;
                        m0       = make_data(CH_J, 7'd0, ROUTE_ARM);
                        m1       = make_data(CH_F, 7'd1, ROUTE_ARM);
                        n_in_arm = 1'b1;
                        n_arm    = AC_W'(2);
                        go       = 1'b0;
                    end else begin
                        // release the J as the first byte of a text line
                        have_pre  = 1'b1;
                        pre       = make_data(CH_J, 7'd0, ROUTE_ROVER);
                        eff_count = LC_W'(1);
                        eff_prog  = PROG_FAILED;
                        n_count   = eff_count;
                        n_prog    = eff_prog;
                    end
                end
                if (go) begin
                    if (i_byte == CH_J && eff_count == '0) begin
                        n_held_j = 1'b1;
                    end else if (i_byte == CH_LF) begin
                        if (eff_count != '0) begin
                            ok      = (eff_prog == PROG_N_COMMA) && r_comma && r_tail;
                            have_m0 = 1'b1;
                            m0      = make_marker(ok ? KIND_ACCEPT : KIND_DISCARD,
                                                  ROUTE_ROVER, 8'(eff_count));
                            n_count = '0;
                            n_prog  = PROG_START;
                            n_id    = '0;
                            n_comma = 1'b0;
                            n_tail  = 1'b0;
                            n_class = ROUTE_NONE;
                        end
                    end else if (i_byte == CH_CR) begin
                        n_count = eff_count;
                    end else if (eff_count < LC_W'(LINE_MAX)) begin
                        have_m0 = 1'b1;
                        m0      = make_data(i_byte, 7'(eff_count), ROUTE_ROVER);
                        n_count = eff_count + LC_W'(1);
                        case (eff_prog)
                            PROG_START: begin
                                n_prog = (i_byte == CH_0) ? PROG_ZERO : PROG_FAILED;
                            end
                            PROG_ZERO: begin
                                n_prog = (i_byte == CH_X_UP || i_byte == CH_X_LOW) ?
                                         PROG_X : PROG_FAILED;
                            end
                            PROG_X: begin
                                if (i_byte == CH_3 || i_byte == CH_4) begin
                                    n_id   = {8'd0, hex_val(i_byte)};
                                    n_prog = PROG_D1;
                                end else begin
                                    n_prog = PROG_FAILED;
                                end
                            end
                            PROG_D1: begin
                                if (i_byte == CH_COMMA) begin
                                    n_comma = 1'b1;
                                    n_prog  = PROG_N_COMMA;
                                end else if (is_hex(i_byte)) begin
                                    if (id_next > 16'(ID_MAX)) begin
                                        n_prog = PROG_FAILED;
                                    end else begin
                                        n_id = id_next[11:0];
                                    end
                                end else begin
                                    n_prog = PROG_FAILED;
                                end
                            end
                            PROG_N_COMMA: begin
                                n_tail = 1'b1;
                            end
                            default: begin
                                n_prog = eff_prog;
                            end
                        endcase
                    end else begin
                        // drop the byte and discard the full line
                        have_m0 = 1'b1;
                        m0      = make_marker(KIND_DISCARD, ROUTE_ROVER, 8'(eff_count));
                        n_count = '0;
                        n_prog  = PROG_START;
                        n_id    = '0;
                        n_comma = 1'b0;
                        n_tail  = 1'b0;
                        n_class = ROUTE_NONE;
                    end
                end
            end
        end else begin
            if (i_byte == CH_CR) begin
                n_count = r_count;
            end else if (i_byte == CH_LF) begin
                if (r_ovf || r_count != '0) begin
                    if (!r_ovf) begin
                        ok      = (r_prog == PROG_S_TAIL) && r_tail && (r_class != ROUTE_NONE);
                        have_m0 = 1'b1;
                        m0      = make_marker(ok ? KIND_ACCEPT : KIND_DISCARD,
                                              ok ? r_class : ROUTE_NONE, 8'(r_count));
                    end
                    n_ovf   = 1'b0;
                    n_count = '0;
                    n_prog  = PROG_START;
                    n_id    = '0;
                    n_comma = 1'b0;
                    n_tail  = 1'b0;
                    n_class = ROUTE_NONE;
                end
            end else if (r_ovf) begin
                n_ovf = 1'b1;
            end else if (r_count < LC_W'(LINE_MAX)) begin
                have_m0 = 1'b1;
                m0      = make_data(i_byte, 7'(r_count), ROUTE_NONE);
                n_count = r_count + LC_W'(1);
                case (r_prog)
                    PROG_START: begin
                        n_prog = (i_byte == CH_0) ? PROG_ZERO : PROG_FAILED;
                    end
                    PROG_ZERO: begin
                        n_prog = (i_byte == CH_X_UP || i_byte == CH_X_LOW) ?
                                 PROG_X : PROG_FAILED;
                    end
                    PROG_X: begin
                        if (!is_hex(i_byte)) begin
                            n_prog = PROG_FAILED;
                        end else begin
                            n_prog = PROG_D1;
                            if (i_byte == CH_5) begin
                                n_class = ROUTE_SCIENCE;
                            end else if (i_byte == CH_3 || i_byte == CH_4) begin
                                n_class = ROUTE_ROVER;
                            end else begin
                                n_class = ROUTE_NONE;
                            end
                        end
                    end
                    PROG_D1, PROG_D2: begin
                        n_prog = is_hex(i_byte) ? r_prog + 4'd1 : PROG_FAILED;
                    end
                    PROG_D3: begin
                        if (i_byte == CH_COMMA) begin
                            n_comma = 1'b1;
                            n_prog  = PROG_S_COMMA;
                        end else begin
                            n_prog = PROG_FAILED;
                        end
                    end
                    PROG_S_COMMA: begin
                        n_tail = 1'b1;
                        n_prog = PROG_S_TAIL;
                    end
                    default: begin
                        n_prog = r_prog;
                    end
                endcase
            end else begin
                // discard the full line, then drop bytes up to the next LF
                have_m0 = 1'b1;
                m0      = make_marker(KIND_DISCARD, ROUTE_NONE, 8'(r_count));
                n_ovf   = 1'b1;
                n_count = '0;
                n_prog  = PROG_START;
                n_id    = '0;
                n_comma = 1'b0;
                n_tail  = 1'b0;
                n_class = ROUTE_NONE;
            end
        end

        // order results: released J first, then the byte's own results
        step.r0  = have_pre ? pre : m0;
        step.r1  = have_pre ? m0  : m1;
        step.num = 2'(have_pre) + 2'(have_m0) + 2'(have_m1);
        if (step.num == 2'd2) begin
            step.r1.last = 1'b1;
        end else if (step.num == 2'd1) begin
            step.r0.last = 1'b1;
        end
    end

    assign o_step = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_science <= 1'b0;
            r_in_arm  <= 1'b0;
            r_held_j  <= 1'b0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_arm     <= '0;
            r_prog    <= PROG_START;
            r_id      <= '0;
            r_comma   <= 1'b0;
            r_tail    <= 1'b0;
            r_class   <= ROUTE_NONE;
        end else if (i_cfg_we && i_cfg_wdata != r_science) begin
            // mode change: drop any packet in progress without a marker
            r_science <= i_cfg_wdata;
            r_in_arm  <= 1'b0;
            r_held_j  <= 1'b0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_arm     <= '0;
            r_prog    <= PROG_START;
            r_id      <= '0;
            r_comma   <= 1'b0;
            r_tail    <= 1'b0;
            r_class   <= ROUTE_NONE;
        end else if (i_valid) begin
            r_in_arm  <= n_in_arm;
            r_held_j  <= n_held_j;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_arm     <= n_arm;
            r_prog    <= n_prog;
            r_id      <= n_id;
            r_comma   <= n_comma;
            r_tail    <= n_tail;
            r_class   <= n_class;
        end
    end

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_step.num == 2'd2) |->
            (o_step.r0.kind == KIND_DATA && !o_step.r0.last && o_step.r1.last))
        else $error("two-result step out of order");

    a_arm_normal_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_arm || r_held_j) |-> !r_science)
        else $error("arm packet state active in science mode");

    a_arm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_arm |-> (r_arm >= AC_W'(2) && r_arm < AC_W'(ARM_LEN)))
        else $error("arm byte count out of range");

endmodule
